// File: rtl/core/mwa_pkg.sv
// ----------------------------------------------------------------------------
// Max window average package
// Widths, reset values and divider handshake types shared by the block.
// ----------------------------------------------------------------------------
package mwa_pkg;

  localparam int LEN_W     = 11;              // window length register
  localparam int SUM_W     = 26;              // running and best window sums
  localparam int FRAC_W    = 16;              // fraction bits of the average
  localparam int AVG_W     = 32;              // average output
  localparam int NUM_W     = SUM_W + FRAC_W;  // dividend magnitude
  localparam int DIV_CNT_W = $clog2(NUM_W);

  localparam logic [LEN_W-1:0] LEN_RESET = LEN_W'(4);

  typedef struct packed {
    logic             start;
    logic [NUM_W-1:0] dividend;
    logic [LEN_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [NUM_W-1:0] quot;
    logic             rem_nz;
  } div_res_t;

endpackage

// File: rtl/core/mwa_in_if.sv
// ----------------------------------------------------------------------------
// Max window average input channel
// Valid/ready channel carrying one sample and its last-of-sequence flag.
// ----------------------------------------------------------------------------
interface mwa_in_if #(
  parameter int SAMPLE_BITS = 16
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample;
  logic                          last;

  modport source (output valid, output sample, output last, input ready);
  modport sink   (input valid, input sample, input last, output ready);
endinterface

// File: rtl/core/mwa_out_if.sv
// ----------------------------------------------------------------------------
// Max window average output channel
// Valid/ready channel carrying the best window sum, its average and a flag.
// ----------------------------------------------------------------------------
interface mwa_out_if;
  logic                              valid;
  logic                              ready;
  logic signed [mwa_pkg::SUM_W-1:0]  max_sum;
  logic signed [mwa_pkg::AVG_W-1:0]  max_avg_q16;
  logic                              found;

  modport source (output valid, output max_sum, output max_avg_q16, output found,
                  input ready);
  modport sink   (input valid, input max_sum, input max_avg_q16, input found,
                  output ready);
endinterface

// File: rtl/core/mwa_div.sv
// ----------------------------------------------------------------------------
// Max window average divider
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module mwa_div (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  mwa_pkg::div_req_t req_i,
  output mwa_pkg::div_res_t res_o
);
  import mwa_pkg::*;

  logic                 busy_q;
  logic                 done_q;
  logic [DIV_CNT_W-1:0] cnt_q;
  logic [NUM_W-1:0]     acc_q;
  logic [LEN_W-1:0]     rem_q;
  logic [LEN_W-1:0]     divisor_q;

  logic [LEN_W:0]       shifted;
  logic                 qbit;
  logic [LEN_W:0]       diff;

  // The partial remainder stays below the divisor, so LEN_W bits hold it.
  assign shifted = {rem_q, acc_q[NUM_W-1]};
  assign qbit    = shifted >= {1'b0, divisor_q};
  assign diff    = shifted - {1'b0, divisor_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == DIV_CNT_W'(NUM_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      acc_q     <= req_i.dividend;
      rem_q     <= '0;
      divisor_q <= req_i.divisor;
    end else if (busy_q) begin
      acc_q <= {acc_q[NUM_W-2:0], qbit};
      rem_q <= qbit ? diff[LEN_W-1:0] : shifted[LEN_W-1:0];
    end
  end

  assign res_o.done   = done_q;
  assign res_o.quot   = acc_q;
  assign res_o.rem_nz = |rem_q;

endmodule

// File: rtl/core/max_window_average.sv
// Input: a sample that completes a window is followed by the delay-line read
// (S_READ) and subtract (S_SUB) before the next is taken. The result of a last
// sample passes S_FIN, then S_DIV for the divider if a window was found, to S_OUT.
// Reset: asynchronous, active low; the window length returns to 4 and all
// sequence state clears. The delay line is not cleared.
// ----------------------------------------------------------------------------
// Max window average
// Tracks the largest sum over a sliding window of samples and reports it with
// its floored Q16 average at the end of each sequence.
// ----------------------------------------------------------------------------
module max_window_average #(
  parameter int MAX_WINDOW  = 1024,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [mwa_pkg::LEN_W-1:0] cfg_wdata_i,
  mwa_in_if.sink                    in_i,
  mwa_out_if.source                 out_o
);
  import mwa_pkg::*;

  localparam int AW    = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int CNT_W = $clog2(MAX_WINDOW + 1);
  localparam int CW    = (CNT_W > LEN_W) ? CNT_W : LEN_W;
  localparam int XW    = NUM_W + 2;

  localparam logic signed [XW-1:0] AVG_MAX = XW'(64'sd2147483647);
  localparam logic signed [XW-1:0] AVG_MIN = -XW'(64'sd2147483648);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_READ = 3'd1;
  localparam logic [2:0] S_SUB  = 3'd2;
  localparam logic [2:0] S_FIN  = 3'd3;
  localparam logic [2:0] S_DIV  = 3'd4;
  localparam logic [2:0] S_OUT  = 3'd5;

  logic [2:0]              state_q, state_d;
  logic [LEN_W-1:0]        window_len_q;
  logic [AW-1:0]           wp_q;
  logic [CNT_W-1:0]        fill_q;
  logic signed [SUM_W-1:0] ws_q;
  logic signed [SUM_W-1:0] best_q;
  logic                    best_valid_q;
  logic                    last_q;
  logic [LEN_W-1:0]        k_q;
  logic [AW-1:0]           rd_addr_q;
  logic [SAMPLE_BITS-1:0]  rdata_q;
  logic                    neg_q;
  logic signed [SUM_W-1:0] max_sum_q;
  logic signed [AVG_W-1:0] avg_q;
  logic                    found_q;

  logic [SAMPLE_BITS-1:0]  mem [MAX_WINDOW];

  logic                    in_fire;
  logic [LEN_W-1:0]        k;
  logic [AW-1:0]           km1;
  logic [AW-1:0]           old_addr;
  logic [AW-1:0]           wp_next;
  logic [CNT_W-1:0]        fill_inc;
  logic                    full;
  logic [SUM_W-1:0]        best_mag;
  logic signed [XW-1:0]    q_ext;
  logic signed [XW-1:0]    avg_full;
  logic signed [AVG_W-1:0] avg_sat;
  div_req_t                div_req;
  div_res_t                div_res;

  assign in_fire = in_i.valid && in_i.ready;

  // Effective window length: zero counts as one, and it never exceeds the line.
  always_comb begin
    k = (window_len_q == '0) ? LEN_W'(1) : window_len_q;
    if (32'(k) > MAX_WINDOW) begin
      k = LEN_W'(MAX_WINDOW);
    end
  end

  // Oldest sample of the current window, wrapping around the delay line.
  assign km1 = AW'(k - 1'b1);
  always_comb begin
    if (wp_q >= km1) begin
      old_addr = wp_q - km1;
    end else begin
      old_addr = AW'((AW+1)'(wp_q) + (AW+1)'(MAX_WINDOW) - (AW+1)'(km1));
    end
  end

  assign wp_next  = ((AW+1)'(wp_q) + 1'b1 == (AW+1)'(MAX_WINDOW)) ? '0 : wp_q + 1'b1;
  assign fill_inc = (fill_q < CNT_W'(MAX_WINDOW)) ? fill_q + 1'b1 : fill_q;
  assign full     = CW'(fill_inc) >= CW'(k);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          if (full) begin
            state_d = S_READ;
          end else if (in_i.last) begin
            state_d = S_FIN;
          end
        end
      end
      S_READ: state_d = S_SUB;
      S_SUB:  state_d = last_q ? S_FIN : S_IDLE;
      S_FIN:  state_d = best_valid_q ? S_DIV : S_OUT;
      S_DIV: begin
        if (div_res.done) begin
          state_d = S_OUT;
        end
      end
      S_OUT: begin
        if (out_o.ready) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      window_len_q <= LEN_RESET;
      wp_q         <= '0;
      fill_q       <= '0;
      ws_q         <= '0;
      best_q       <= '0;
      best_valid_q <= 1'b0;
      last_q       <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        window_len_q <= cfg_wdata_i;
      end
      if (in_fire) begin
        ws_q   <= ws_q + SUM_W'(in_i.sample);
        fill_q <= fill_inc;
        last_q <= in_i.last;
        wp_q   <= wp_next;
      end
      if (state_q == S_READ && (!best_valid_q || ws_q > best_q)) begin
        best_q       <= ws_q;
        best_valid_q <= 1'b1;
      end
      if (state_q == S_SUB) begin
        ws_q <= ws_q - SUM_W'($signed(rdata_q));
      end
      if (state_q == S_FIN) begin
        wp_q         <= '0;
        fill_q       <= '0;
        ws_q         <= '0;
        best_q       <= '0;
        best_valid_q <= 1'b0;
      end
    end
  end

  // Delay line and per-transaction captures.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      mem[wp_q] <= in_i.sample;
      k_q       <= k;
      rd_addr_q <= old_addr;
    end
    if (state_q == S_READ) begin
      rdata_q <= mem[rd_addr_q];
    end
  end

  // Result formation: the divider works on the magnitude, the sign and the
  // floor correction are applied afterwards.
  assign best_mag = best_q[SUM_W-1] ? SUM_W'(-best_q) : SUM_W'(best_q);

  always_comb begin
    div_req.start    = (state_q == S_FIN) && best_valid_q;
    div_req.dividend = {best_mag, {FRAC_W{1'b0}}};
    div_req.divisor  = k_q;
  end

  mwa_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .res_o  (div_res)
  );

  assign q_ext    = $signed({2'b00, div_res.quot});
  assign avg_full = neg_q ? -(q_ext + XW'(div_res.rem_nz)) : q_ext;

  always_comb begin
    if (avg_full > AVG_MAX) begin
      avg_sat = AVG_W'(AVG_MAX);
    end else if (avg_full < AVG_MIN) begin
      avg_sat = AVG_W'(AVG_MIN);
    end else begin
      avg_sat = AVG_W'(avg_full);
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_FIN) begin
      max_sum_q <= best_q;
      found_q   <= best_valid_q;
      neg_q     <= best_q[SUM_W-1];
      avg_q     <= '0;
    end
    if (state_q == S_DIV && div_res.done) begin
      avg_q <= avg_sat;
    end
  end

  assign in_i.ready        = (state_q == S_IDLE);
  assign out_o.valid       = (state_q == S_OUT);
  assign out_o.max_sum     = max_sum_q;
  assign out_o.max_avg_q16 = avg_q;
  assign out_o.found       = found_q;

endmodule

// File: dv/max_window_average_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Max window average testbench
// Streams sample sequences into the block with bursty valid and stalling
// ready, and runs window length changes between and inside sequences. Each
// end-of-sequence result is checked field by field against a cycle-free
// model of the sliding window kept alongside the stimulus.
// ----------------------------------------------------------------------------
module max_window_average_tb;

  import mwa_pkg::*;

  localparam real CLK_PERIOD    = 8.0;
  localparam int  MAX_WIN       = 1024;
  localparam int  SAMPLE_W      = 16;
  localparam int  RAND_ITEMS    = 950;
  localparam int  SETTLE_CYCLES = 16;
  localparam int  TAIL_CYCLES   = 64;
  localparam int  LONG_HOLD     = 400;
  localparam int  CYCLE_LIMIT   = 400000;

  typedef enum logic [1:0] {STIM_SAMPLE, STIM_CFG, STIM_DRAIN, STIM_HOLD} stim_kind_e;

  typedef struct {
    stim_kind_e                  kind;
    logic signed [SAMPLE_W-1:0]  sample;
    logic                        last;
    logic [LEN_W-1:0]            len;
  } stim_entry_t;

  typedef struct packed {
    logic signed [SUM_W-1:0] max_sum;
    logic signed [AVG_W-1:0] max_avg_q16;
    logic                    found;
  } peak_result_t;

  logic             clk_i;
  logic             rst_ni;
  logic             cfg_we;
  logic [LEN_W-1:0] cfg_wdata;

  mwa_in_if #(.SAMPLE_BITS(SAMPLE_W)) in_if ();
  mwa_out_if                          out_if ();

  max_window_average #(
    .MAX_WINDOW  (MAX_WIN),
    .SAMPLE_BITS (SAMPLE_W)
  ) i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .in_i        (in_if),
    .out_o       (out_if)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  stim_entry_t  stim_q[$];
  peak_result_t peak_q[$];

  // Window tracking state mirrored from the block.
  logic signed [SAMPLE_W-1:0] hist_mem [MAX_WIN];
  logic [9:0]                 wr_pos;
  logic [LEN_W-1:0]           n_filled;
  logic signed [SUM_W-1:0]    run_sum;
  logic signed [SUM_W-1:0]    peak_sum;
  logic                       peak_valid;
  logic [LEN_W-1:0]           len_reg;

  int fail_cnt;
  int samples_sent;
  int lens_written;
  int results_seen;
  int found_seen;
  int cycle_cnt;
  int hold_asked;

  // Driver and receiver bookkeeping.
  int burst_left;
  int gap_left;
  int settle_cnt;
  int hold_served;
  int hold_left;
  int sink_mode;
  int pattern_left;
  int beat;

  function automatic void clear_window();
    wr_pos     = '0;
    n_filled   = '0;
    run_sum    = '0;
    peak_sum   = '0;
    peak_valid = 1'b0;
  endfunction

  function automatic int eff_window(logic [LEN_W-1:0] len);
    if (len == 0) return 1;
    if (len > MAX_WIN) return MAX_WIN;
    return int'(len);
  endfunction

  // Advances the window by one sample; on the last sample of a sequence the
  // best sum and its floored Q16 average are queued and the sequence restarts.
  function automatic void track_window(logic signed [SAMPLE_W-1:0] s, logic lst);
    int           k;
    logic [9:0]   old_idx;
    longint       num;
    longint       den;
    longint       quo;
    peak_result_t res;
    k = eff_window(len_reg);
    hist_mem[wr_pos] = s;
    run_sum = run_sum + s;
    if (n_filled < MAX_WIN) n_filled = n_filled + 1'b1;
    if (int'(n_filled) >= k) begin
      if (!peak_valid || run_sum > peak_sum) begin
        peak_sum   = run_sum;
        peak_valid = 1'b1;
      end
      old_idx = wr_pos - 10'(k - 1);
      run_sum = run_sum - hist_mem[old_idx];
    end
    wr_pos = wr_pos + 1'b1;
    if (!lst) return;
    res = '0;
    if (peak_valid) begin
      den = longint'(k);
      num = longint'(peak_sum) * 64'sd65536;
      quo = num / den;
      if ((num % den) != 0 && num < 0) quo = quo - 1;
      if (quo > 64'sd2147483647) quo = 64'sd2147483647;
      if (quo < -64'sd2147483648) quo = -64'sd2147483648;
      res.max_sum     = peak_sum;
      res.max_avg_q16 = quo[AVG_W-1:0];
      res.found       = 1'b1;
    end
    peak_q.push_back(res);
    clear_window();
  endfunction

  function automatic void push_sample(logic signed [SAMPLE_W-1:0] s, logic lst);
    stim_entry_t e;
    e.kind   = STIM_SAMPLE;
    e.sample = s;
    e.last   = lst;
    e.len    = '0;
    stim_q.push_back(e);
  endfunction

  function automatic void push_cfg(logic [LEN_W-1:0] len);
    stim_entry_t e;
    e.kind   = STIM_CFG;
    e.sample = '0;
    e.last   = 1'b0;
    e.len    = len;
    stim_q.push_back(e);
  endfunction

  function automatic void push_marker(stim_kind_e kind);
    stim_entry_t e;
    e.kind   = kind;
    e.sample = '0;
    e.last   = 1'b0;
    e.len    = '0;
    stim_q.push_back(e);
  endfunction

  // Modes: full range, small values, extremes, negative only, large positive;
  // anything higher mixes them per sample.
  function automatic logic signed [SAMPLE_W-1:0] draw_sample(int mode);
    int m;
    m = (mode > 4) ? int'($urandom_range(0, 4)) : mode;
    case (m)
      0: return SAMPLE_W'($urandom);
      1: return SAMPLE_W'(int'($urandom_range(0, 200)) - 100);
      2: begin
        case ($urandom_range(0, 3))
          0: return 16'sh8000;
          1: return 16'sh7fff;
          2: return -16'sd1;
          default: return 16'sd0;
        endcase
      end
      3: return SAMPLE_W'(-int'($urandom_range(1, 32768)));
      default: return SAMPLE_W'(int'($urandom_range(16384, 32767)));
    endcase
  endfunction

  // A mid_pos of -1 means the window length stays put for the whole sequence.
  function automatic void push_sequence(int n, int mode, int mid_pos, logic [LEN_W-1:0] mid_len);
    for (int i = 0; i < n; i++) begin
      if (i == mid_pos) push_cfg(mid_len);
      push_sample(draw_sample(mode), i == n - 1);
    end
  endfunction

  initial begin
    int               rand_items;
    int               n;
    int               k;
    int               mid;
    logic [LEN_W-1:0] cur_len;
    logic [LEN_W-1:0] new_len;
    bit               hold_done;

    clk_i           = 1'b0;
    rst_ni          = 1'b0;

    // Directed: reset length, extremes, short sequences and the odd lengths.
    push_sample(16'sh8000, 1'b0);
    push_sample(16'sh7fff, 1'b0);
    push_sample(16'sd0, 1'b0);
    push_sample(16'sd5, 1'b0);
    push_sample(-16'sd1, 1'b1);
    push_sample(16'sd1, 1'b0);
    push_sample(16'sd2, 1'b1);
    push_cfg(11'd0);
    push_sample(16'sh8000, 1'b0);
    push_sample(-16'sd5, 1'b1);
    push_cfg(11'd2047);
    push_sample(16'sd7, 1'b1);
    push_cfg(11'd1);
    push_sample(16'sh7fff, 1'b1);
    // Shrinking the window mid-sequence pushes the average past both rails.
    push_cfg(11'd4);
    repeat (4) push_sample(16'sh7fff, 1'b0);
    push_cfg(11'd1);
    push_sample(16'sh7fff, 1'b1);
    push_cfg(11'd4);
    repeat (4) push_sample(16'sh8000, 1'b0);
    push_cfg(11'd1);
    push_sample(16'sh8000, 1'b1);

    rand_items = 0;
    hold_done  = 1'b0;
    cur_len    = 11'd1;
    new_len    = '0;
    while (rand_items < RAND_ITEMS) begin
      if (!hold_done && rand_items >= 150) begin
        // Short sequences keep the divider busy while the receiver holds off.
        hold_done = 1'b1;
        cur_len   = 11'd2;
        push_cfg(cur_len);
        push_marker(STIM_HOLD);
        repeat (30) begin
          n = $urandom_range(1, 6);
          push_sequence(n, 5, -1, '0);
          rand_items += n;
        end
        push_marker(STIM_DRAIN);
      end else begin
        case ($urandom_range(0, 9))
          0:          cur_len = 11'd0;
          1:          cur_len = 11'd1;
          2, 3, 4, 5: cur_len = LEN_W'($urandom_range(2, 8));
          6, 7:       cur_len = LEN_W'($urandom_range(9, 32));
          8:          cur_len = LEN_W'($urandom_range(1025, 2047));
          default:    cur_len = LEN_W'($urandom_range(33, 64));
        endcase
        push_cfg(cur_len);
        repeat ($urandom_range(2, 8)) begin
          if (rand_items < RAND_ITEMS) begin
            k = eff_window(cur_len);
            n = (k == MAX_WIN) ? $urandom_range(1, 12) : $urandom_range(1, 2 * k + 4);
            if (n > RAND_ITEMS - rand_items) n = RAND_ITEMS - rand_items;
            mid = ($urandom_range(0, 11) == 0) ? int'($urandom_range(0, n - 1)) : -1;
            if (mid >= 0) new_len = LEN_W'($urandom_range(0, 8));
            push_sequence(n, $urandom_range(0, 5), mid, new_len);
            if (mid >= 0) cur_len = new_len;
            rand_items += n;
          end
        end
      end
    end

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (stim_q.size() != 0 || in_if.valid || peak_q.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);

    $display("Ran %0d samples over %0d window length writes, including zero, one and",
             samples_sent, lens_written);
    $display("out-of-range lengths; checked %0d sequence results, %0d with a full window.",
             results_seen, found_seen);
    if (fail_cnt == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // Sender: offers queued samples in bursts and writes the window length once
  // nothing is outstanding and the block has had time to settle.
  always @(posedge clk_i or negedge rst_ni) begin : feed_driver
    logic                       nxt_valid;
    logic signed [SAMPLE_W-1:0] nxt_sample;
    logic                       nxt_last;
    logic                       nxt_we;
    logic [LEN_W-1:0]           nxt_wdata;
    stim_entry_t                head;
    if (!rst_ni) begin
      in_if.valid  <= 1'b0;
      in_if.sample <= '0;
      in_if.last   <= 1'b0;
      cfg_we       <= 1'b0;
      cfg_wdata    <= LEN_RESET;
      hold_asked   <= 0;
      burst_left   = 1;
      gap_left     = 0;
      settle_cnt   = 0;
      len_reg      = LEN_RESET;
      clear_window();
    end else begin
      nxt_valid  = in_if.valid;
      nxt_sample = in_if.sample;
      nxt_last   = in_if.last;
      nxt_we     = 1'b0;
      nxt_wdata  = cfg_wdata;
      if (in_if.valid && in_if.ready) begin
        track_window(in_if.sample, in_if.last);
        samples_sent++;
        nxt_valid = 1'b0;
      end
      if (!nxt_valid) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (stim_q.size() != 0) begin
          head = stim_q[0];
          case (head.kind)
            STIM_SAMPLE: begin
              void'(stim_q.pop_front());
              nxt_valid  = 1'b1;
              nxt_sample = head.sample;
              nxt_last   = head.last;
              burst_left--;
              if (burst_left <= 0) begin
                if ($urandom_range(0, 3) == 0) begin
                  burst_left = $urandom_range(50, 200);
                  gap_left   = 0;
                end else begin
                  burst_left = $urandom_range(1, 12);
                  gap_left   = $urandom_range(0, 6);
                end
              end
            end
            STIM_HOLD: begin
              void'(stim_q.pop_front());
              hold_asked <= hold_asked + 1;
            end
            default: begin
              if (peak_q.size() != 0) begin
                settle_cnt = 0;
              end else if (settle_cnt < SETTLE_CYCLES) begin
                settle_cnt++;
              end else begin
                settle_cnt = 0;
                void'(stim_q.pop_front());
                if (head.kind == STIM_CFG) begin
                  nxt_we    = 1'b1;
                  nxt_wdata = head.len;
                  len_reg   = head.len;
                  lens_written++;
                end
              end
            end
          endcase
        end
      end
      in_if.valid  <= nxt_valid;
      in_if.sample <= nxt_sample;
      in_if.last   <= nxt_last;
      cfg_we       <= nxt_we;
      cfg_wdata    <= nxt_wdata;
    end
  end

  // Receiver: switches between always ready, random and periodic stalls, and
  // holds off for a long stretch when the sender asks for it.
  always @(posedge clk_i or negedge rst_ni) begin : sink_stall
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
      hold_served  = 0;
      hold_left    = 0;
      sink_mode    = 0;
      pattern_left = 0;
      beat         = 0;
    end else begin
      if (hold_served != hold_asked) begin
        hold_served = hold_asked;
        hold_left   = LONG_HOLD;
      end
      if (pattern_left == 0) begin
        sink_mode    = $urandom_range(0, 2);
        pattern_left = $urandom_range(20, 200);
      end else begin
        pattern_left--;
      end
      beat++;
      if (hold_left > 0) begin
        hold_left--;
        out_if.ready <= 1'b0;
      end else begin
        case (sink_mode)
          0:       out_if.ready <= 1'b1;
          1:       out_if.ready <= 1'($urandom_range(0, 1));
          default: out_if.ready <= (beat % 7) < 4;
        endcase
      end
    end
  end

  always @(posedge clk_i) begin : result_monitor
    peak_result_t want;
    if (rst_ni && out_if.valid && out_if.ready) begin
      results_seen++;
      if (out_if.found) found_seen++;
      if (peak_q.size() == 0) begin
        $error("result with nothing pending: max_sum %0d, max_avg_q16 %0d, found %0b",
               out_if.max_sum, out_if.max_avg_q16, out_if.found);
        fail_cnt++;
      end else begin
        want = peak_q.pop_front();
        if (out_if.max_sum !== want.max_sum) begin
          $error("max_sum mismatch: expected %0d, got %0d", want.max_sum, out_if.max_sum);
          fail_cnt++;
        end
        if (out_if.max_avg_q16 !== want.max_avg_q16) begin
          $error("max_avg_q16 mismatch: expected %0d, got %0d",
                 want.max_avg_q16, out_if.max_avg_q16);
          fail_cnt++;
        end
        if (out_if.found !== want.found) begin
          $error("found mismatch: expected %0b, got %0b", want.found, out_if.found);
          fail_cnt++;
        end
      end
    end
  end

  always @(posedge clk_i) begin : watchdog
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

endmodule

// File: max_window_average.f
rtl/core/mwa_pkg.sv
rtl/core/mwa_in_if.sv
rtl/core/mwa_out_if.sv
rtl/core/mwa_div.sv
rtl/core/max_window_average.sv
dv/max_window_average_tb.sv
